### hdl/jec_pkg.sv
// shared types, constants and helpers of the julia escape-time chunk engine
package jec_pkg;

  localparam int COORD_BITS   = 32;
  localparam int FRAC_BITS    = 28;
  localparam int PROD_BITS    = 2 * COORD_BITS;
  localparam int SUM_BITS     = PROD_BITS + 2;
  localparam int ITER_BITS    = 16;
  localparam int COUNT_BITS   = ITER_BITS + 1;
  localparam int ID_BITS      = 16;
  localparam int DIM_BITS     = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0] SUM_TOP =
    {{(SUM_BITS-COORD_BITS){1'b0}}, COORD_MAX};
  localparam logic signed [SUM_BITS-1:0] SUM_BOT =
    {{(SUM_BITS-COORD_BITS){1'b1}}, COORD_MIN};
  localparam logic [PROD_BITS:0] ESC_LIMIT = (PROD_BITS+1)'(1) << (2 * FRAC_BITS + 2);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CONST_RE = 3'd0,
    CFG_CONST_IM = 3'd1,
    CFG_STEP_RE  = 3'd2,
    CFG_STEP_IM  = 3'd3,
    CFG_MAX_ITER = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_NEXT = 1'b1
  } action_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] step_re;
    logic signed [COORD_BITS-1:0] step_im;
  } step_cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] const_re;
    logic signed [COORD_BITS-1:0] const_im;
    logic [ITER_BITS-1:0]         max_iter;
  } core_cfg_t;

  typedef struct packed {
    logic                         has_pixel;
    logic [ID_BITS-1:0]           chunk_id;
    logic [DIM_BITS-1:0]          col;
    logic [DIM_BITS-1:0]          row;
    logic signed [COORD_BITS-1:0] z_re;
    logic signed [COORD_BITS-1:0] z_im;
  } job_t;

  typedef struct packed {
    logic                  has_pixel;
    logic [ID_BITS-1:0]    chunk_id;
    logic [DIM_BITS-1:0]   col;
    logic [DIM_BITS-1:0]   row;
    logic [COUNT_BITS-1:0] iterations;
  } result_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [COORD_BITS-1:0] r;
    if (v > SUM_TOP) r = COORD_MAX;
    else if (v < SUM_BOT) r = COORD_MIN;
    else r = v[COORD_BITS-1:0];
    return r;
  endfunction

endpackage

### hdl/jec_front.sv
// front end: takes load and next transactions, walks the chunk, emits start points
module jec_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_action,
  input  logic [15:0]            in_chunk_id,
  input  logic signed [jec_pkg::COORD_BITS-1:0] in_start_re,
  input  logic signed [jec_pkg::COORD_BITS-1:0] in_start_im,
  input  logic [7:0]             in_chunk_width,
  input  logic [7:0]             in_chunk_height,
  input  jec_pkg::step_cfg_t     step_cfg,
  output logic                   push_valid,
  input  logic                   push_ready,
  output jec_pkg::job_t          push_data
);
  import jec_pkg::*;

  logic [ID_BITS-1:0]           chunk_id_r;
  logic signed [COORD_BITS-1:0] origin_re_r;
  logic signed [COORD_BITS-1:0] origin_im_r;
  logic [DIM_BITS-1:0]          width_r;
  logic [DIM_BITS-1:0]          height_r;
  logic [DIM_BITS-1:0]          col_r;
  logic [DIM_BITS-1:0]          row_r;

  logic                           accept;
  logic                           in_pixel;
  logic [DIM_BITS-1:0]            row_inc;
  logic signed [COORD_BITS+DIM_BITS:0] off_re;
  logic signed [COORD_BITS+DIM_BITS:0] off_im;
  logic signed [SUM_BITS-1:0]     pos_re;
  logic signed [SUM_BITS-1:0]     pos_im;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign in_pixel = (col_r < width_r) && (row_r < height_r);
  assign row_inc  = row_r + 1'b1;

  always_comb begin
    off_re = (COORD_BITS+DIM_BITS+1)'($signed({1'b0, col_r})) *
             (COORD_BITS+DIM_BITS+1)'(step_cfg.step_re);
    off_im = (COORD_BITS+DIM_BITS+1)'($signed({1'b0, row_r})) *
             (COORD_BITS+DIM_BITS+1)'(step_cfg.step_im);
    pos_re = SUM_BITS'(origin_re_r) + SUM_BITS'(off_re);
    pos_im = SUM_BITS'(origin_im_r) + SUM_BITS'(off_im);
    push_valid          = accept && (in_action == ACT_NEXT);
    push_data.chunk_id  = chunk_id_r;
    if (in_pixel) begin
      push_data.has_pixel = 1'b1;
      push_data.col       = col_r;
      push_data.row       = row_r;
      push_data.z_re      = sat_coord(pos_re);
      push_data.z_im      = sat_coord(pos_im);
    end else begin
      push_data.has_pixel = 1'b0;
      push_data.col       = '0;
      push_data.row       = '0;
      push_data.z_re      = '0;
      push_data.z_im      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_id_r  <= '0;
      origin_re_r <= '0;
      origin_im_r <= '0;
      width_r     <= '0;
      height_r    <= '0;
      col_r       <= '0;
      row_r       <= '0;
    end else if (accept) begin
      if (in_action == ACT_LOAD) begin
        chunk_id_r  <= in_chunk_id;
        origin_re_r <= in_start_re;
        origin_im_r <= in_start_im;
        width_r     <= in_chunk_width;
        height_r    <= in_chunk_height;
        col_r       <= '0;
        row_r       <= '0;
      end else if (in_pixel) begin
        if (row_inc == height_r) begin
          row_r <= '0;
          col_r <= col_r + 1'b1;
        end else begin
          row_r <= row_inc;
        end
      end else begin
        col_r <= '0;
        row_r <= '0;
      end
    end
  end

endmodule

### hdl/jec_queue.sv
// short job queue between the front end and the iteration core
module jec_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  jec_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output jec_pkg::job_t pop_data
);
  import jec_pkg::*;

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;

  logic do_push;
  logic do_pop;

  assign push_ready = (count_r != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    logic [QPTR_BITS-1:0] r;
    if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not shrink on pop");

endmodule

### hdl/jec_core.sv
// iteration core: z = z^2 + c escape-time loop with output register
module jec_core (
  input  logic               clk,
  input  logic               rst_n,
  input  jec_pkg::core_cfg_t core_cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  jec_pkg::job_t      pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jec_pkg::result_t   out_data
);
  import jec_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_HOLD
  } state_t;

  state_t                       state_r;
  logic                         has_pixel_r;
  logic [ID_BITS-1:0]           chunk_id_r;
  logic [DIM_BITS-1:0]          col_r;
  logic [DIM_BITS-1:0]          row_r;
  logic signed [COORD_BITS-1:0] z_re_r;
  logic signed [COORD_BITS-1:0] z_im_r;
  logic [COUNT_BITS-1:0]        k_r;
  logic [PROD_BITS-1:0]         rr_r;
  logic [PROD_BITS-1:0]         ii_r;
  logic [PROD_BITS-1:0]         ri_r;
  logic                         neg_im_r;
  logic                         esc_r;
  logic signed [SUM_BITS-1:0]   nre_r;
  logic signed [SUM_BITS-1:0]   nim_r;
  logic                         out_valid_r;
  result_t                      out_data_r;

  logic [COORD_BITS-1:0]      mr;
  logic [COORD_BITS-1:0]      mi;
  logic [PROD_BITS:0]         mag_sq;
  logic                       ii_gt;
  logic [PROD_BITS-1:0]       diff;
  logic [SUM_BITS-1:0]        re_mag;
  logic [SUM_BITS-1:0]        im_mag;
  logic signed [SUM_BITS-1:0] nre;
  logic signed [SUM_BITS-1:0] nim;
  logic                       slot_free;
  logic                       last_iter;

  assign pop_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;
  assign last_iter = (k_r == {1'b0, core_cfg.max_iter});

  always_comb begin
    mr     = z_re_r[COORD_BITS-1] ? (~z_re_r + 1'b1) : z_re_r;
    mi     = z_im_r[COORD_BITS-1] ? (~z_im_r + 1'b1) : z_im_r;
    mag_sq = {1'b0, rr_r} + {1'b0, ii_r};
    ii_gt  = ii_r > rr_r;
    diff   = ii_gt ? (ii_r - rr_r) : (rr_r - ii_r);
    re_mag = SUM_BITS'(diff >> FRAC_BITS);
    im_mag = SUM_BITS'(ri_r >> (FRAC_BITS - 1));
    nre    = ii_gt ? -$signed(re_mag) : $signed(re_mag);
    nim    = neg_im_r ? -$signed(im_mag) : $signed(im_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ((state_r == ST_HOLD) && slot_free) || (out_valid_r && !out_ready);
      unique case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            has_pixel_r <= pop_data.has_pixel;
            chunk_id_r  <= pop_data.chunk_id;
            col_r       <= pop_data.col;
            row_r       <= pop_data.row;
            z_re_r      <= pop_data.z_re;
            z_im_r      <= pop_data.z_im;
            k_r         <= '0;
            state_r     <= pop_data.has_pixel ? ST_MUL : ST_HOLD;
          end
        end
        ST_MUL: begin
          rr_r     <= PROD_BITS'(mr) * PROD_BITS'(mr);
          ii_r     <= PROD_BITS'(mi) * PROD_BITS'(mi);
          ri_r     <= PROD_BITS'(mr) * PROD_BITS'(mi);
          neg_im_r <= z_re_r[COORD_BITS-1] ^ z_im_r[COORD_BITS-1];
          state_r  <= ST_SUM;
        end
        ST_SUM: begin
          esc_r   <= mag_sq > ESC_LIMIT;
          nre_r   <= nre;
          nim_r   <= nim;
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (esc_r) begin
            state_r <= ST_HOLD;
          end else begin
            k_r    <= k_r + 1'b1;
            z_re_r <= sat_coord(nre_r + SUM_BITS'(core_cfg.const_re));
            z_im_r <= sat_coord(nim_r + SUM_BITS'(core_cfg.const_im));
            state_r <= last_iter ? ST_HOLD : ST_MUL;
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            out_data_r.has_pixel  <= has_pixel_r;
            out_data_r.chunk_id   <= chunk_id_r;
            out_data_r.col        <= col_r;
            out_data_r.row        <= row_r;
            out_data_r.iterations <= k_r;
            state_r               <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (k_r <= {1'b0, core_cfg.max_iter} + 1'b1))
    else $error("iteration count past limit");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.has_pixel) |->
      (out_data_r.iterations == '0 && out_data_r.col == '0 && out_data_r.row == '0))
    else $error("end marker carries pixel data");

  a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && out_valid_r && !out_ready) |=> (state_r == ST_HOLD))
    else $error("result dropped while output stalled");

endmodule

### hdl/julia_escape_time_chunk.sv
// top level of the julia escape-time chunk engine: config registers and datapath
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | action, chunk id, start point, chunk size
//  out     | output    | out_valid / out_ready | has_pixel, chunk id, col, row, iterations
//  cfg     | input     | cfg_valid / cfg_ready | register index, write data
//
// a load transaction gives no result; an end marker goes straight to the output hold state
// a pixel runs one pass of the shared multiply / sum / update loop in the core per
// iteration, until it escapes at count n or, never escaping, reaches count max_iter+1
// the front end keeps accepting into a two-entry job queue while the core iterates
// reset is synchronous, active low; it clears config registers, chunk state, queue counters
// out_valid holds with its payload until taken; a stalled output holds the core, then
// fills the queue and stalls the input
module julia_escape_time_chunk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [15:0]           in_chunk_id,
  input  logic signed [jec_pkg::COORD_BITS-1:0] in_start_re,
  input  logic signed [jec_pkg::COORD_BITS-1:0] in_start_im,
  input  logic [7:0]            in_chunk_width,
  input  logic [7:0]            in_chunk_height,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_has_pixel,
  output logic [15:0]           out_chunk_id,
  output logic [7:0]            out_pixel_col,
  output logic [7:0]            out_pixel_row,
  output logic [16:0]           out_iterations,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [jec_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [jec_pkg::COORD_BITS-1:0]   cfg_data
);
  import jec_pkg::*;

  step_cfg_t step_cfg_r;
  core_cfg_t core_cfg_r;

  logic    push_valid;
  logic    push_ready;
  job_t    push_data;
  logic    pop_valid;
  logic    pop_ready;
  job_t    pop_data;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cfg_r <= '0;
      core_cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CONST_RE: core_cfg_r.const_re <= cfg_data;
        CFG_CONST_IM: core_cfg_r.const_im <= cfg_data;
        CFG_STEP_RE:  step_cfg_r.step_re  <= cfg_data;
        CFG_STEP_IM:  step_cfg_r.step_im  <= cfg_data;
        CFG_MAX_ITER: core_cfg_r.max_iter <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  jec_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_chunk_id     (in_chunk_id),
    .in_start_re     (in_start_re),
    .in_start_im     (in_start_im),
    .in_chunk_width  (in_chunk_width),
    .in_chunk_height (in_chunk_height),
    .step_cfg        (step_cfg_r),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  jec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  jec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .core_cfg  (core_cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign out_has_pixel  = res.has_pixel;
  assign out_chunk_id   = res.chunk_id;
  assign out_pixel_col  = res.col;
  assign out_pixel_row  = res.row;
  assign out_iterations = res.iterations;

endmodule

### tb/julia_escape_time_chunk_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the julia escape-time chunk engine with its own pixel predictor
module julia_escape_time_chunk_test;
  import jec_pkg::*;

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CFG_SPARE_FIRST = int'(CFG_MAX_ITER) + 1;
  localparam int Q_ONE           = 1 << FRAC_BITS;

  typedef struct {
    action_t                      action;
    logic [ID_BITS-1:0]           id;
    logic signed [COORD_BITS-1:0] start_re;
    logic signed [COORD_BITS-1:0] start_im;
    logic [DIM_BITS-1:0]          width;
    logic [DIM_BITS-1:0]          height;
  } chunk_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [15:0] in_chunk_id = '0;
  logic signed [COORD_BITS-1:0] in_start_re = '0;
  logic signed [COORD_BITS-1:0] in_start_im = '0;
  logic [7:0] in_chunk_width = '0;
  logic [7:0] in_chunk_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_has_pixel;
  logic [15:0] out_chunk_id;
  logic [7:0] out_pixel_col;
  logic [7:0] out_pixel_row;
  logic [16:0] out_iterations;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data = '0;

  // predictor copy of the registers and the chunk state
  logic signed [COORD_BITS-1:0] c_re = '0, c_im = '0, st_re = '0, st_im = '0;
  logic [ITER_BITS-1:0] iter_cap = '0;
  logic [ID_BITS-1:0] cur_id = '0;
  logic signed [COORD_BITS-1:0] org_re = '0, org_im = '0;
  logic [DIM_BITS-1:0] span_w = '0, span_h = '0, col_at = '0, row_at = '0;

  chunk_cmd_t commands[$];
  chunk_cmd_t driven_cmd;
  result_t awaited_pixels[$];
  bit in_took = 1'b0;
  int send_idle_pct = 27;
  int recv_idle_pct = 77;
  int errors = 0;
  int cycle_count = 0;

  julia_escape_time_chunk dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_chunk_id(in_chunk_id), .in_start_re(in_start_re), .in_start_im(in_start_im),
    .in_chunk_width(in_chunk_width), .in_chunk_height(in_chunk_height),
    .out_valid(out_valid), .out_ready(out_ready), .out_has_pixel(out_has_pixel),
    .out_chunk_id(out_chunk_id), .out_pixel_col(out_pixel_col),
    .out_pixel_row(out_pixel_row), .out_iterations(out_iterations),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** julia_escape_time_chunk: FAILED **");
      $finish;
    end
  end

  function automatic longint clamp_coord(longint v);
    if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
    if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
    return v;
  endfunction

  function automatic logic [COUNT_BITS-1:0] escape_count_of(longint re0, longint im0);
    longint re, im, nre, nim;
    logic [63:0] mr, mi;
    logic [SUM_BITS-1:0] rr, ii, ri;
    int k;
    re = re0;
    im = im0;
    for (k = 0; k <= int'(iter_cap); k++) begin
      mr = (re < 0) ? -re : re;
      mi = (im < 0) ? -im : im;
      rr = SUM_BITS'(mr) * SUM_BITS'(mr);
      ii = SUM_BITS'(mi) * SUM_BITS'(mi);
      if (rr + ii > ESC_LIMIT) return COUNT_BITS'(k);
      // magnitudes are truncated, so the real part rounds toward zero
      if (ii > rr) nre = -longint'((ii - rr) >> FRAC_BITS);
      else nre = longint'((rr - ii) >> FRAC_BITS);
      ri = SUM_BITS'(mr) * SUM_BITS'(mi);
      nim = longint'(ri >> (FRAC_BITS - 1));
      if ((re < 0) != (im < 0)) nim = -nim;
      re = clamp_coord(nre + c_re);
      im = clamp_coord(nim + c_im);
    end
    return COUNT_BITS'(k);
  endfunction

  task automatic walk_chunk(chunk_cmd_t cmd);
    result_t r;
    longint zr, zi;
    if (cmd.action == ACT_LOAD) begin
      cur_id = cmd.id;
      org_re = cmd.start_re;
      org_im = cmd.start_im;
      span_w = cmd.width;
      span_h = cmd.height;
      col_at = '0;
      row_at = '0;
    end else begin
      r = '0;
      r.chunk_id = cur_id;
      if (col_at < span_w && row_at < span_h) begin
        zr = clamp_coord(longint'(org_re) + longint'(col_at) * longint'(st_re));
        zi = clamp_coord(longint'(org_im) + longint'(row_at) * longint'(st_im));
        r.has_pixel = 1'b1;
        r.col = col_at;
        r.row = row_at;
        r.iterations = escape_count_of(zr, zi);
        row_at = row_at + 1'b1;
        if (row_at == span_h) begin
          row_at = '0;
          col_at = col_at + 1'b1;
        end
      end else begin
        col_at = '0;
        row_at = '0;
      end
      awaited_pixels.push_back(r);
    end
  endtask

  task automatic log_error(string msg);
    errors++;
    if (errors <= 100) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) log_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // input transaction accepted: advance the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      walk_chunk(driven_cmd);
      in_took = 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_pixels.size() == 0) begin
        log_error("result transaction with nothing awaited");
      end else begin
        want = awaited_pixels.pop_front();
        check_field("has_pixel", out_has_pixel, want.has_pixel);
        check_field("chunk_id", out_chunk_id, want.chunk_id);
        check_field("pixel_col", out_pixel_col, want.col);
        check_field("pixel_row", out_pixel_row, want.row);
        check_field("iterations", out_iterations, want.iterations);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_n && (!in_valid || in_took)) begin
      if (commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        driven_cmd = commands.pop_front();
        in_action <= driven_cmd.action;
        in_chunk_id <= driven_cmd.id;
        in_start_re <= driven_cmd.start_re;
        in_start_im <= driven_cmd.start_im;
        in_chunk_width <= driven_cmd.width;
        in_chunk_height <= driven_cmd.height;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  task automatic queue_load(logic [15:0] id, logic signed [31:0] sr, logic signed [31:0] si,
                            logic [7:0] w, logic [7:0] h);
    chunk_cmd_t c;
    c.action = ACT_LOAD;
    c.id = id;
    c.start_re = sr;
    c.start_im = si;
    c.width = w;
    c.height = h;
    commands.push_back(c);
  endtask

  task automatic queue_next(int n);
    chunk_cmd_t c;
    repeat (n) begin
      c.action = ACT_NEXT;
      c.id = ID_BITS'($urandom);
      c.start_re = $urandom;
      c.start_im = $urandom;
      c.width = DIM_BITS'($urandom);
      c.height = DIM_BITS'($urandom);
      commands.push_back(c);
    end
  endtask

  // hold off until every transaction is taken and every result is back
  task automatic settle();
    while (commands.size() != 0 || in_valid || awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CONST_RE: c_re = val;
      CFG_CONST_IM: c_im = val;
      CFG_STEP_RE:  st_re = val;
      CFG_STEP_IM:  st_im = val;
      CFG_MAX_ITER: iter_cap = val[ITER_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic close_writes();
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [31:0] cre, logic [31:0] cim, logic [31:0] sre,
                                logic [31:0] sim, logic [15:0] mi);
    settle();
    write_reg(CFG_CONST_RE, cre);
    write_reg(CFG_CONST_IM, cim);
    write_reg(CFG_STEP_RE, sre);
    write_reg(CFG_STEP_IM, sim);
    write_reg(CFG_MAX_ITER, {16'b0, mi});
    close_writes();
  endtask

  function automatic logic signed [31:0] rand_q(int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  task automatic random_settings(bit wild);
    if (wild) apply_settings($urandom, $urandom, $urandom, $urandom,
                             16'($urandom_range(0, 15)));
    else apply_settings(rand_q(Q_ONE), rand_q(Q_ONE), rand_q(Q_ONE / 8), rand_q(Q_ONE / 8),
                        16'($urandom_range(1, 48)));
  endtask

  task automatic random_chunks(int budget, bit wild);
    int pushed, kind, w, h, n;
    bit far;
    logic signed [31:0] sr, si;
    pushed = 0;
    while (pushed < budget) begin
      kind = $urandom_range(0, 9);
      far = wild || ($urandom_range(0, 7) == 0);
      sr = far ? $urandom : rand_q(2 * Q_ONE);
      si = far ? $urandom : rand_q(2 * Q_ONE);
      if (kind <= 6) begin
        // whole chunk read out up to its end marker
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
        queue_load(16'($urandom), sr, si, 8'(w), 8'(h));
        n = w * h + 1;
      end else if (kind == 7) begin
        queue_load(16'($urandom), sr, si, 8'($urandom), 8'($urandom));
        n = $urandom_range(0, 5);
      end else if (kind == 8) begin
        if ($urandom_range(0, 1)) queue_load(16'($urandom), sr, si, 8'd0, 8'($urandom));
        else queue_load(16'($urandom), sr, si, 8'($urandom), 8'd0);
        n = $urandom_range(1, 2);
      end else begin
        n = $urandom_range(1, 3);
      end
      queue_next(n);
      pushed += n + ((kind <= 8) ? 1 : 0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset state holds an empty chunk
    queue_next(1);
    apply_settings(-32'sd214748365, 32'sd41875931, 32'sd13421773, -32'sd13421773, 16'd40);
    for (int i = CFG_SPARE_FIRST; i < (1 << CFG_IDX_BITS); i++)
      write_reg(CFG_IDX_BITS'(i), $urandom);
    close_writes();

    queue_load(16'hFFFF, -32'sd429496730, 32'sd322122547, 8'd3, 8'd2);
    queue_next(8);
    queue_load(16'h0000, COORD_MIN, COORD_MAX, 8'd255, 8'd255);
    queue_next(2);
    queue_load(16'h1234, 32'sd0, 32'sd0, 8'd0, 8'd7);
    queue_next(1);
    queue_load(16'h00AA, 32'sd0, 32'sd0, 8'd9, 8'd0);
    queue_next(1);
    queue_load(16'h5555, 32'sd0, 32'sd0, 8'd1, 8'd255);
    queue_next(3);
    queue_load(16'hA5A5, 32'sd80530637, -32'sd134217728, 8'd2, 8'd1);
    queue_next(3);

    apply_settings(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 16'd0);
    queue_load(16'h8001, 32'sd0, 32'sd0, 8'd3, 8'd3);
    queue_next(10);
    queue_load(16'h7FFE, COORD_MIN, COORD_MIN, 8'd2, 8'd2);
    queue_next(5);

    // longest count: origin with c at zero never escapes
    apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF);
    queue_load(16'h0F0F, 32'sd0, 32'sd0, 8'd1, 8'd1);
    queue_next(2);
    queue_load(16'hF0F0, 32'sd805306368, 32'sd0, 8'd1, 8'd1);
    queue_next(1);

    random_settings(1'b0);
    random_chunks(90, 1'b0);

    send_idle_pct = 77;
    recv_idle_pct = 27;
    random_settings(1'b1);
    random_chunks(80, 1'b1);
    random_settings(1'b0);
    random_chunks(35, 1'b0);
    settle();
    random_chunks(35, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_settings(1'b0);
    random_chunks(90, 1'b0);
    random_settings(1'b1);
    random_chunks(70, 1'b1);

    settle();
    if (errors == 0) begin
      $display("** julia_escape_time_chunk: PASSED **");
    end else begin
      $display("** julia_escape_time_chunk: FAILED **");
    end
    $finish;
  end

endmodule

### julia_escape_time_chunk.f
hdl/jec_pkg.sv
hdl/jec_front.sv
hdl/jec_queue.sv
hdl/jec_core.sv
hdl/julia_escape_time_chunk.sv
tb/julia_escape_time_chunk_test.sv
